// ===== hw/rtl/wswa_pkg.sv =====
// Shared types and constants of the wheel speed estimator.
`timescale 1ns / 1ps

package wswa_pkg;

    localparam int OP_W      = 2;
    localparam int CYCLES_W  = 32;
    localparam int SPEED_W   = 32;
    localparam int PERIOD_W  = 27;
    localparam int TIME_W    = 32;
    localparam int CPU_W     = 8;
    localparam int TIMEOUT_W = 16;
    localparam int MRPM_W    = 36;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [OP_W-1:0] OP_EDGE   = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
    localparam logic [OP_W-1:0] OP_REPORT = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_CYCLES_PER_US = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_MS    = 1'b1;

    localparam logic [CPU_W-1:0]     CPU_RESET     = 8'd48;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd100;

    localparam logic [PERIOD_W-1:0] PERIOD_MAX     = 27'h7FF_FFFF;
    localparam logic [SPEED_W-1:0]  SPEED_MAX      = 32'hFFFF_FFFF;
    localparam logic [MRPM_W-1:0]   MRPM_NUMERATOR = 36'd60000000000;

    typedef struct packed {
        logic load_edge;
        logic load_report;
        logic tick;
        logic edge_clear;
        logic edge_start;
        logic edge_latch;
        logic edge_update;
        logic rep_check;
        logic store_zero;
        logic rd_newest;
        logic div_avg;
        logic div_speed_ram;
        logic div_speed_avg;
        logic store_speed;
        logic next_wheel;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic wheel_ok;
        logic ignore_sel;
        logic rep_zero;
        logic rep_partial;
        logic div_done;
        logic last_wheel;
        logic out_free;
    } dp_status_t;

endpackage

// ===== hw/rtl/wswa_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
`timescale 1ns / 1ps

module wswa_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 54
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/wswa_div.sv =====
// Iterative restoring divider that retires one quotient bit per cycle.
`timescale 1ns / 1ps

module wswa_div #(
    parameter int NUM_W = 36,
    parameter int DEN_W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quot_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] count_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   rem_shift;
    logic [DEN_W+1:0] diff;
    logic             borrow;

    // A zero divisor never borrows, so the quotient comes out as all ones.
    assign rem_shift = {rem_reg, quot_reg[NUM_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, den_reg};
    assign borrow    = diff[DEN_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= num;
            rem_reg  <= '0;
            den_reg  <= den;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[NUM_W-2:0], ~borrow};
            if (!borrow)
            begin
                rem_reg <= diff[DEN_W-1:0];
            end
            else
            begin
                rem_reg <= rem_shift[DEN_W-1:0];
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== hw/rtl/wswa_datapath.sv =====
// Datapath: per-wheel state, period ring, shared divider and result register.
`timescale 1ns / 1ps

module wswa_datapath
    import wswa_pkg::*;
#(
    parameter int TEETH  = 27,
    parameter int WHEELS = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    output dp_status_t           status,
    input  logic                 wheel,
    input  logic [CYCLES_W-1:0]  capture_cycles,
    input  logic [CPU_W-1:0]     cycles_per_us,
    input  logic [TIMEOUT_W-1:0] timeout_limit,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [SPEED_W-1:0]   right_speed_mrpm,
    output logic [SPEED_W-1:0]   left_speed_mrpm
);

    localparam int WEIGHT_TOTAL = TEETH * (TEETH + 1) / 2;
    localparam int POS_W   = $clog2(TEETH);
    localparam int FILL_W  = $clog2(TEETH + 1);
    localparam int WHEEL_W = (WHEELS > 1) ? $clog2(WHEELS) : 1;
    localparam int DEPTH   = WHEELS * TEETH;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int WIN_W   = PERIOD_W + $clog2(TEETH + 1);
    localparam int WSUM_W  = PERIOD_W + $clog2(WEIGHT_TOTAL + 1);
    localparam int NUM_A   = (MRPM_W > WSUM_W) ? MRPM_W : WSUM_W;
    localparam int NUM_W   = (NUM_A > CYCLES_W) ? NUM_A : CYCLES_W;
    localparam int WT_W    = $clog2(WEIGHT_TOTAL + 1);
    localparam int DEN_A   = (WIN_W > CPU_W) ? WIN_W : CPU_W;
    localparam int DEN_W   = (DEN_A > WT_W) ? DEN_A : WT_W;

    logic [WHEEL_W-1:0]  wheel_reg;
    logic [CYCLES_W-1:0] cycles_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [POS_W-1:0]    pos_reg       [WHEELS];
    logic [FILL_W-1:0]   fill_reg      [WHEELS];
    logic [WSUM_W-1:0]   wsum_reg      [WHEELS];
    logic [WIN_W-1:0]    win_reg       [WHEELS];
    logic                ignore_reg    [WHEELS];
    logic [TIME_W-1:0]   last_time_reg [WHEELS];
    logic [TIME_W-1:0]   ms_count_reg;
    logic [SPEED_W-1:0]  speed0_reg;
    logic [SPEED_W-1:0]  speed1_reg;
    logic                out_valid_reg;
    logic [SPEED_W-1:0]  right_reg;
    logic [SPEED_W-1:0]  left_reg;

    logic [POS_W-1:0]    pos_sel;
    logic [FILL_W-1:0]   fill_sel;
    logic [WSUM_W-1:0]   wsum_sel;
    logic [WIN_W-1:0]    win_sel;
    logic [POS_W-1:0]    newest_pos;
    logic [ADDR_W-1:0]   base_addr;
    logic [ADDR_W-1:0]   pos_addr;
    logic [ADDR_W-1:0]   newest_addr;
    logic                ram_rd_en;
    logic [ADDR_W-1:0]   ram_rd_addr;
    logic [PERIOD_W-1:0] ram_rd_data;

    logic                div_start;
    logic [NUM_W-1:0]    div_num;
    logic [DEN_W-1:0]    div_den;
    logic                div_busy;
    logic                div_done;
    logic [NUM_W-1:0]    div_quot;
    logic [PERIOD_W-1:0] speed_period;
    logic [PERIOD_W-1:0] period_sat;
    logic [SPEED_W-1:0]  speed_sat;

    logic [PERIOD_W-1:0] old_period;
    logic [POS_W-1:0]    pos_next;
    logic [FILL_W-1:0]   fill_next;
    logic [WSUM_W-1:0]   wsum_next;
    logic [WIN_W-1:0]    win_next;
    logic [TIME_W-1:0]   elapsed;
    logic                timed_out;

    assign pos_sel  = pos_reg[wheel_reg];
    assign fill_sel = fill_reg[wheel_reg];
    assign wsum_sel = wsum_reg[wheel_reg];
    assign win_sel  = win_reg[wheel_reg];

    assign newest_pos  = (pos_sel == '0) ? POS_W'(TEETH - 1) : pos_sel - 1'b1;
    assign base_addr   = ADDR_W'(wheel_reg) * ADDR_W'(TEETH);
    assign pos_addr    = base_addr + ADDR_W'(pos_sel);
    assign newest_addr = base_addr + ADDR_W'(newest_pos);
    assign ram_rd_en   = cmd.edge_start | cmd.rd_newest;
    assign ram_rd_addr = cmd.rd_newest ? newest_addr : pos_addr;

    wswa_ram #(
        .WIDTH (PERIOD_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (cmd.edge_update),
        .wr_addr (pos_addr),
        .wr_data (period_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign div_start    = cmd.edge_start | cmd.div_avg | cmd.div_speed_ram
                        | cmd.div_speed_avg;
    assign speed_period = cmd.div_speed_ram ? ram_rd_data : div_quot[PERIOD_W-1:0];

    always_comb
    begin
        if (cmd.edge_start)
        begin
            div_num = NUM_W'(cycles_reg);
            div_den = DEN_W'(cycles_per_us);
        end
        else if (cmd.div_avg)
        begin
            div_num = NUM_W'(wsum_sel);
            div_den = DEN_W'(WEIGHT_TOTAL);
        end
        else
        begin
            div_num = NUM_W'(MRPM_NUMERATOR);
            div_den = DEN_W'(TEETH) * DEN_W'(speed_period);
        end
    end

    wswa_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign period_sat = (div_quot > NUM_W'(PERIOD_MAX)) ? PERIOD_MAX
                                                        : div_quot[PERIOD_W-1:0];
    assign speed_sat  = (div_quot > NUM_W'(SPEED_MAX)) ? SPEED_MAX
                                                       : div_quot[SPEED_W-1:0];

    assign old_period = (fill_sel >= FILL_W'(TEETH)) ? ram_rd_data : '0;
    assign pos_next   = (pos_sel == POS_W'(TEETH - 1)) ? '0 : pos_sel + 1'b1;
    assign fill_next  = (fill_sel < FILL_W'(TEETH)) ? fill_sel + 1'b1 : fill_sel;
    assign wsum_next  = wsum_sel + WSUM_W'(TEETH) * WSUM_W'(period_reg)
                      - WSUM_W'(win_sel);
    assign win_next   = win_sel + WIN_W'(period_reg) - WIN_W'(old_period);

    assign elapsed   = ms_count_reg - last_time_reg[wheel_reg];
    assign timed_out = elapsed > TIME_W'(timeout_limit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_reg     <= '0;
            ms_count_reg  <= '0;
            speed0_reg    <= '0;
            speed1_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < WHEELS; i++)
            begin
                pos_reg[i]       <= '0;
                fill_reg[i]      <= '0;
                wsum_reg[i]      <= '0;
                win_reg[i]       <= '0;
                ignore_reg[i]    <= 1'b0;
                last_time_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.load_edge)
            begin
                wheel_reg <= WHEEL_W'(wheel);
            end
            else if (cmd.load_report)
            begin
                wheel_reg <= '0;
            end
            else if (cmd.next_wheel)
            begin
                wheel_reg <= wheel_reg + 1'b1;
            end

            if (cmd.tick)
            begin
                ms_count_reg <= ms_count_reg + 1'b1;
            end

            if (cmd.edge_clear)
            begin
                pos_reg[wheel_reg]       <= '0;
                fill_reg[wheel_reg]      <= '0;
                wsum_reg[wheel_reg]      <= '0;
                win_reg[wheel_reg]       <= '0;
                last_time_reg[wheel_reg] <= ms_count_reg;
            end
            else if (cmd.edge_update)
            begin
                pos_reg[wheel_reg]       <= pos_next;
                fill_reg[wheel_reg]      <= fill_next;
                wsum_reg[wheel_reg]      <= wsum_next;
                win_reg[wheel_reg]       <= win_next;
                last_time_reg[wheel_reg] <= ms_count_reg;
            end

            if (cmd.rep_check)
            begin
                ignore_reg[wheel_reg] <= timed_out;
            end

            if (cmd.store_zero || cmd.store_speed)
            begin
                if (wheel_reg == WHEEL_W'(0))
                begin
                    speed0_reg <= cmd.store_zero ? '0 : speed_sat;
                end
                else if (wheel_reg == WHEEL_W'(1))
                begin
                    speed1_reg <= cmd.store_zero ? '0 : speed_sat;
                end
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_edge)
        begin
            cycles_reg <= capture_cycles;
        end
        if (cmd.edge_latch)
        begin
            period_reg <= period_sat;
        end
        if (cmd.out_load)
        begin
            right_reg <= speed0_reg;
            left_reg  <= speed1_reg;
        end
    end

    assign status.wheel_ok    = 32'(wheel) < 32'(WHEELS);
    assign status.ignore_sel  = ignore_reg[wheel_reg];
    assign status.rep_zero    = timed_out || (fill_sel == '0);
    assign status.rep_partial = fill_sel < FILL_W'(TEETH);
    assign status.div_done    = div_done;
    assign status.last_wheel  = wheel_reg == WHEEL_W'(WHEELS - 1);
    assign status.out_free    = !out_valid_reg || out_ready;

    assign out_valid        = out_valid_reg;
    assign right_speed_mrpm = right_reg;
    assign left_speed_mrpm  = left_reg;

    a_div_start_idle : assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("Divider started while a division is still running.");

    a_no_update_when_ignored : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.edge_update |-> !ignore_reg[wheel_reg])
        else $error("Ring updated for a wheel whose edges are ignored.");

    a_no_result_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("Result register loaded over a beat not yet taken.");

    a_fill_bounded : assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg[wheel_reg] <= FILL_W'(TEETH))
        else $error("Fill count beyond the ring length.");

endmodule

// ===== hw/rtl/wswa_ctrl.sv =====
// Controller state machine that sequences edges, ticks and speed reports.
`timescale 1ns / 1ps

module wswa_ctrl
    import wswa_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [OP_W-1:0] op,
    output dp_cmd_t         cmd,
    input  dp_status_t      status
);

    localparam logic [3:0] ST_IDLE        = 4'd0;
    localparam logic [3:0] ST_EDGE_START  = 4'd1;
    localparam logic [3:0] ST_EDGE_DIV    = 4'd2;
    localparam logic [3:0] ST_EDGE_UPDATE = 4'd3;
    localparam logic [3:0] ST_REP_CHECK   = 4'd4;
    localparam logic [3:0] ST_REP_READ    = 4'd5;
    localparam logic [3:0] ST_REP_AVG     = 4'd6;
    localparam logic [3:0] ST_REP_AVG_SPD = 4'd7;
    localparam logic [3:0] ST_REP_SPD     = 4'd8;
    localparam logic [3:0] ST_REP_NEXT    = 4'd9;
    localparam logic [3:0] ST_REP_OUT     = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (op)
                        OP_EDGE:
                        begin
                            if (status.wheel_ok)
                            begin
                                cmd.load_edge = 1'b1;
                                state_next    = ST_EDGE_START;
                            end
                        end
                        OP_TICK:
                        begin
                            cmd.tick = 1'b1;
                        end
                        OP_REPORT:
                        begin
                            cmd.load_report = 1'b1;
                            state_next      = ST_REP_CHECK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_EDGE_START:
            begin
                if (status.ignore_sel)
                begin
                    cmd.edge_clear = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    cmd.edge_start = 1'b1;
                    state_next     = ST_EDGE_DIV;
                end
            end
            ST_EDGE_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.edge_latch = 1'b1;
                    state_next     = ST_EDGE_UPDATE;
                end
            end
            ST_EDGE_UPDATE:
            begin
                cmd.edge_update = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_REP_CHECK:
            begin
                cmd.rep_check = 1'b1;
                if (status.rep_zero)
                begin
                    cmd.store_zero = 1'b1;
                    state_next     = ST_REP_NEXT;
                end
                else if (status.rep_partial)
                begin
                    cmd.rd_newest = 1'b1;
                    state_next    = ST_REP_READ;
                end
                else
                begin
                    cmd.div_avg = 1'b1;
                    state_next  = ST_REP_AVG;
                end
            end
            ST_REP_READ:
            begin
                cmd.div_speed_ram = 1'b1;
                state_next        = ST_REP_SPD;
            end
            ST_REP_AVG:
            begin
                if (status.div_done)
                begin
                    state_next = ST_REP_AVG_SPD;
                end
            end
            ST_REP_AVG_SPD:
            begin
                cmd.div_speed_avg = 1'b1;
                state_next        = ST_REP_SPD;
            end
            ST_REP_SPD:
            begin
                if (status.div_done)
                begin
                    cmd.store_speed = 1'b1;
                    state_next      = ST_REP_NEXT;
                end
            end
            ST_REP_NEXT:
            begin
                if (status.last_wheel)
                begin
                    state_next = ST_REP_OUT;
                end
                else
                begin
                    cmd.next_wheel = 1'b1;
                    state_next     = ST_REP_CHECK;
                end
            end
            ST_REP_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/wheel_speed_weighted_average.sv =====
// Top level of the wheel speed estimator: configuration registers and block assembly.
`timescale 1ns / 1ps

// Each tooth edge beat turns its capture count into a period in microseconds, stores it
// in a per-wheel ring of the last TEETH periods and updates a triangular-weighted sum
// and a window sum. A tick beat advances the millisecond counter, and a report beat
// returns both wheel speeds in milli-RPM as one output beat. Items are handled one at a
// time, and all division runs on one shared bit-serial divider of N bits, where N is
// 36 at the default TEETH. An unused code is dropped, and an edge for a wheel that the
// last report found timed out clears that wheel's ring instead. A report stores zero
// for a timed-out or empty wheel and skips the averaging division for a filling one.
// A finished report waits in the output register, and the next item is taken meanwhile.
module wheel_speed_weighted_average
    import wswa_pkg::*;
#(
    parameter int TEETH  = 27,
    parameter int WHEELS = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [OP_W-1:0]        op,
    input  logic                   wheel,
    input  logic [CYCLES_W-1:0]    capture_cycles,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SPEED_W-1:0]     right_speed_mrpm,
    output logic [SPEED_W-1:0]     left_speed_mrpm,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [CPU_W-1:0]     cpu_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    dp_cmd_t              cmd;
    dp_status_t           status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpu_reg     <= CPU_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_CYCLES_PER_US)
            begin
                cpu_reg <= cfg_data[CPU_W-1:0];
            end
            else if (cfg_index == CFG_TIMEOUT_MS)
            begin
                timeout_reg <= cfg_data[TIMEOUT_W-1:0];
            end
        end
    end

    wswa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .cmd      (cmd),
        .status   (status)
    );

    wswa_datapath #(
        .TEETH  (TEETH),
        .WHEELS (WHEELS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .wheel            (wheel),
        .capture_cycles   (capture_cycles),
        .cycles_per_us    (cpu_reg),
        .timeout_limit    (timeout_reg),
        .out_ready        (out_ready),
        .out_valid        (out_valid),
        .right_speed_mrpm (right_speed_mrpm),
        .left_speed_mrpm  (left_speed_mrpm)
    );

endmodule
